// ----- sv/csvt_pkg.sv -----
// Package for the CSV record tokenizer: parser state, token codes and byte constants.
// Used by csvt_step.sv, csv_record_tokenizer.sv and tb_top.sv; depends on nothing.
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] QUOTE_CHAR  = 8'd34;
  localparam logic [7:0] LF_CHAR     = 8'd10;
  localparam logic [7:0] CR_CHAR     = 8'd13;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  typedef enum logic [1:0] {
    EXPECT_NONE = 2'd0,
    EXPECT_LF   = 2'd1,
    EXPECT_CR   = 2'd2
  } expect_t;

  typedef struct packed {
    logic        inside_quotes;
    logic        quote_pending;
    expect_t     pair_skip_expect;
    logic [31:0] row_counter;
  } csvt_state_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] ch;
  } csvt_token_t;

endpackage

`default_nettype wire

// ----- sv/csvt_if.sv -----
// Valid/ready channel interfaces for the CSV record tokenizer: text bytes in, tokens out.
// Depends on nothing but the widths of the fields.
`default_nettype none

interface csvt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface csvt_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  cell_char;
  logic [31:0] rows_done;

  modport source (output valid, output token_kind, output cell_char, output rows_done,
                  input ready);
  modport sink   (input valid, input token_kind, input cell_char, input rows_done,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/csvt_step.sv -----
// Next-state and token logic of the tokenizer for one text byte.
// Depends on csvt_pkg for the state and token structs and the byte constants.
`default_nettype none

module csvt_step (
  input  wire logic [7:0]          c,
  input  wire logic [7:0]          delimiter,
  input  wire csvt_pkg::csvt_state_t st,
  output csvt_pkg::csvt_state_t    st_next,
  output csvt_pkg::csvt_token_t    tok
);
  import csvt_pkg::*;

  logic skip;
  logic unquoted;

  assign skip = ((st.pair_skip_expect == EXPECT_LF) && (c == LF_CHAR)) ||
                ((st.pair_skip_expect == EXPECT_CR) && (c == CR_CHAR));

  always_comb begin
    st_next                  = st;
    st_next.pair_skip_expect = EXPECT_NONE;
    tok.emit                 = 1'b0;
    tok.kind                 = KIND_CHAR;
    tok.ch                   = 8'd0;
    unquoted                 = 1'b0;

    if (!skip) begin
      if (st.quote_pending) begin
        st_next.quote_pending = 1'b0;
        if (c == QUOTE_CHAR) begin
          tok.emit = 1'b1;
          tok.ch   = QUOTE_CHAR;
        end else begin
          // A lone quote closed the section; this byte is handled as unquoted.
          st_next.inside_quotes = 1'b0;
          unquoted              = 1'b1;
        end
      end else if (st.inside_quotes) begin
        if (c == QUOTE_CHAR) begin
          st_next.quote_pending = 1'b1;
        end else begin
          tok.emit = 1'b1;
          tok.ch   = c;
        end
      end else begin
        unquoted = 1'b1;
      end
    end

    if (unquoted) begin
      // The delimiter test comes first, so it wins over quote and line ends.
      priority if (c == delimiter) begin
        tok.emit = 1'b1;
        tok.kind = KIND_CELL;
      end else if (c == QUOTE_CHAR) begin
        st_next.inside_quotes = 1'b1;
      end else if ((c == LF_CHAR) || (c == CR_CHAR)) begin
        if (st.row_counter != '1) begin
          st_next.row_counter = st.row_counter + 32'd1;
        end
        st_next.pair_skip_expect = (c == LF_CHAR) ? EXPECT_CR : EXPECT_LF;
        tok.emit = 1'b1;
        tok.kind = KIND_ROW;
      end else begin
        tok.emit = 1'b1;
        tok.ch   = c;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/csv_record_tokenizer.sv -----
// Top level of the CSV record tokenizer: input register, parser state, result register.
// Depends on csvt_pkg, the channel interfaces in csvt_if.sv and csvt_step.
//
//   channel    direction  payload                              handshake
//   text       in         text_byte[7:0]                       valid/ready
//   token      out        token_kind[1:0] cell_char rows_done  valid/ready
//   delimiter  in         delimiter_data[7:0]                  delimiter_we
//
// One byte per clock sustained while tokens are not stalled. A byte is held in the
// input register, and the parser step between that register and the result register is
// the only logic path. A byte that gives a token passes the input and then the result
// register; skipped bytes and quotes that give none still pass the input register.
// Reset clears the parser state, both valid flags and sets the delimiter to a comma.
// A stalled token holds the result register, and a byte in the input register that
// would give a token then holds too; a byte that gives none still moves on.
`default_nettype none

module csv_record_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  csvt_text_if.sink       text,
  csvt_token_if.source    token,
  input  wire logic       delimiter_we,
  input  wire logic [7:0] delimiter_data
);
  import csvt_pkg::*;

  logic [7:0]  delimiter;
  logic        in_valid;
  logic [7:0]  in_byte;
  csvt_state_t st;
  csvt_state_t st_next;
  csvt_token_t tok;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_char;
  logic [31:0] out_rows;
  logic        out_free;
  logic        step_fire;

  csvt_step u_step (
    .c         (in_byte),
    .delimiter (delimiter),
    .st        (st),
    .st_next   (st_next),
    .tok       (tok)
  );

  // The held word can move on when the result register is empty or being drained, or when it gives no token.
  assign out_free  = !out_valid || token.ready;
  assign step_fire = in_valid && (out_free || !tok.emit);
  assign text.ready = !in_valid || step_fire;

  assign token.valid      = out_valid;
  assign token.token_kind = out_kind;
  assign token.cell_char  = out_char;
  assign token.rows_done  = out_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (delimiter_we) begin
      delimiter <= delimiter_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step_fire && tok.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && tok.emit) begin
      out_kind <= tok.kind;
      out_char <= tok.ch;
      out_rows <= st_next.row_counter;
    end
  end

  a_quote_pending_inside: assert property (@(posedge clk) disable iff (rst)
    st.quote_pending |-> st.inside_quotes)
    else $error("quote pending outside a quoted section");

  a_skip_only_unquoted: assert property (@(posedge clk) disable iff (rst)
    (st.pair_skip_expect != EXPECT_NONE) |-> (!st.inside_quotes && !st.quote_pending))
    else $error("line-end skip armed inside a quoted section");

  a_rows_only_on_row: assert property (@(posedge clk) disable iff (rst)
    (step_fire && !(tok.emit && (tok.kind == KIND_ROW))) |=> $stable(st.row_counter))
    else $error("row count changed without a row end");

  a_no_token_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !token.ready) |=> out_valid)
    else $error("held token dropped while stalled");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for csv_record_tokenizer: random and directed CSV text, token checks.
// Depends on csvt_pkg and the channel interfaces in csvt_if.sv; reads no files.
`default_nettype none

module tb_top;
  import csvt_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [31:0] rows;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       delimiter_we;
  logic [7:0] delimiter_data;

  csvt_text_if  text_ch ();
  csvt_token_if token_ch ();

  csv_record_tokenizer dut (
    .clk            (clk),
    .rst            (rst),
    .text           (text_ch),
    .token          (token_ch),
    .delimiter_we   (delimiter_we),
    .delimiter_data (delimiter_data)
  );

  always #5 clk = ~clk;

  // Parser state as the bench sees it, plus the delimiter it last wrote.
  logic        in_quotes   = 1'b0;
  logic        quote_seen  = 1'b0;
  expect_t     skip_next   = EXPECT_NONE;
  logic [31:0] rows_seen   = 32'd0;
  logic [7:0]  sep_byte    = DELIM_RESET;

  logic [7:0] text_queue [$];
  token_t     expected_tokens [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned errors       = 0;
  int unsigned idle_pct     = 20;

  logic [7:0] opening_text [25];

  function automatic bit tokenize_byte(input logic [7:0] c, output token_t t);
    logic [7:0] want;
    t = '{kind: KIND_CHAR, ch: 8'd0, rows: rows_seen};
    if (skip_next != EXPECT_NONE) begin
      want = (skip_next == EXPECT_LF) ? LF_CHAR : CR_CHAR;
      skip_next = EXPECT_NONE;
      if (c == want) return 1'b0;
    end
    if (quote_seen) begin
      quote_seen = 1'b0;
      if (c == QUOTE_CHAR) begin
        t.ch = QUOTE_CHAR;
        return 1'b1;
      end
      in_quotes = 1'b0;
    end else if (in_quotes) begin
      if (c == QUOTE_CHAR) begin
        quote_seen = 1'b1;
        return 1'b0;
      end
      t.ch = c;
      return 1'b1;
    end
    // Outside quotes the delimiter test wins over quote and line-end bytes.
    if (c == sep_byte) begin
      t.kind = KIND_CELL;
      return 1'b1;
    end
    if (c == QUOTE_CHAR) begin
      in_quotes = 1'b1;
      return 1'b0;
    end
    if (c == LF_CHAR || c == CR_CHAR) begin
      if (rows_seen != 32'hFFFF_FFFF) rows_seen = rows_seen + 32'd1;
      skip_next = (c == LF_CHAR) ? EXPECT_CR : EXPECT_LF;
      t.kind = KIND_ROW;
      t.rows = rows_seen;
      return 1'b1;
    end
    t.ch = c;
    return 1'b1;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    text_queue = {text_queue, b};
    bytes_queued++;
  endtask

  // One record of random cells; most are well formed, some are raw noise or
  // leave a quoted section open.
  task automatic queue_record();
    int cells;
    int style;
    int len;
    logic [7:0] b;
    cells = $urandom_range(1, 4);
    for (int k = 0; k < cells; k++) begin
      if (k != 0) queue_byte(sep_byte);
      style = $urandom_range(0, 9);
      len = $urandom_range(0, 5);
      if (style <= 4) begin
        for (int n = 0; n < len; n++) begin
          b = 8'($urandom_range(32, 126));
          if (b == sep_byte || b == QUOTE_CHAR) b = "x";
          queue_byte(b);
        end
      end else if (style <= 7) begin
        queue_byte(QUOTE_CHAR);
        for (int n = 0; n < len; n++) begin
          b = 8'($urandom_range(0, 255));
          queue_byte(b);
          if (b == QUOTE_CHAR) queue_byte(QUOTE_CHAR);
        end
        queue_byte(QUOTE_CHAR);
      end else if (style == 8) begin
        for (int n = 0; n <= len; n++) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        queue_byte(QUOTE_CHAR);
        for (int n = 0; n < len; n++) queue_byte(8'($urandom_range(32, 126)));
      end
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        queue_byte(CR_CHAR);
        queue_byte(LF_CHAR);
      end
      2: queue_byte(LF_CHAR);
      3: queue_byte(CR_CHAR);
      4: begin
        queue_byte(LF_CHAR);
        queue_byte(CR_CHAR);
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (!(bytes_taken == bytes_queued && expected_tokens.size() == 0)) @(posedge clk);
  endtask

  // Text driver: a word is held until it is taken, then the next one is offered.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= text_queue.pop_front();
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    token_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : text_monitor
    token_t t;
    if (!rst && text_ch.valid && text_ch.ready) begin
      bytes_taken++;
      if (tokenize_byte(text_ch.text_byte, t)) expected_tokens = {expected_tokens, t};
    end
  end

  always @(posedge clk) begin : token_monitor
    token_t t;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind %0d char %0d rows %0d", $time,
                 token_ch.token_kind, token_ch.cell_char, token_ch.rows_done);
      end else begin
        t = expected_tokens.pop_front();
        if (token_ch.token_kind !== t.kind || token_ch.cell_char !== t.ch ||
            token_ch.rows_done !== t.rows) begin
          errors++;
          $display("%0t: token mismatch: expected kind %0d char %0d rows %0d, got kind %0d char %0d rows %0d",
                   $time, t.kind, t.ch, t.rows,
                   token_ch.token_kind, token_ch.cell_char, token_ch.rows_done);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [7:0] delims [8];
    int unsigned target;
    delimiter_we      <= 1'b0;
    delimiter_data    <= 8'd0;
    delims = '{DELIM_RESET, 8'h00, 8'hFF, QUOTE_CHAR, CR_CHAR, LF_CHAR, 8'h09,
               8'($urandom_range(0, 255))};
    // Doubled quotes, CRLF and LFCR pairs, repeated CRs, byte extremes, an empty
    // quoted cell, and line ends and delimiters inside quotes.
    opening_text = '{"a", ",", QUOTE_CHAR, "x", QUOTE_CHAR, QUOTE_CHAR, "y", QUOTE_CHAR,
                     CR_CHAR, LF_CHAR, LF_CHAR, CR_CHAR, CR_CHAR, CR_CHAR, 8'h00, 8'hFF,
                     QUOTE_CHAR, QUOTE_CHAR, ",", QUOTE_CHAR, ",", LF_CHAR, QUOTE_CHAR,
                     "z", LF_CHAR};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        // The sender stays quiet until every token of the last phase is back.
        wait_drained();
        repeat (4) @(posedge clk);
        delimiter_we   <= 1'b1;
        delimiter_data <= delims[p];
        sep_byte = delims[p];
        @(posedge clk);
        delimiter_we <= 1'b0;
      end
      idle_pct = (p == 3) ? 0 : 20;
      if (p == 0) begin
        foreach (opening_text[k]) queue_byte(opening_text[k]);
      end
      // Short fixed text that meets the delimiter in every setting, including
      // when it equals a quote or a line-end byte.
      queue_byte(QUOTE_CHAR);
      queue_byte("a");
      queue_byte(CR_CHAR);
      queue_byte(LF_CHAR);
      queue_byte(sep_byte);
      queue_byte(LF_CHAR);
      queue_byte(CR_CHAR);
      queue_byte(QUOTE_CHAR);
      queue_byte(QUOTE_CHAR);
      queue_byte(QUOTE_CHAR);
      queue_byte("b");
      queue_byte(QUOTE_CHAR);
      queue_byte("c");
      queue_byte(CR_CHAR);
      target = bytes_queued + 125;
      while (bytes_queued < target) queue_record();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
